[design/ordered_array_insert_delete_search_defines.svh]
// assertion macros for the ordered array block
// expects signals named clock and reset in the scope that uses them
`ifndef ORDERED_ARRAY_INSERT_DELETE_SEARCH_DEFINES_SVH
`define ORDERED_ARRAY_INSERT_DELETE_SEARCH_DEFINES_SVH

// property that holds in every cycle outside reset
`define OAIDS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition in one cycle implies a property in the next
`define OAIDS_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

[design/oaids_pkg.sv]
// shared types and codes for the ordered array block
// no dependencies
package oaids_pkg;

   localparam int DATA_W = 32;
   localparam int POS_W  = 9;
   localparam int FPOS_W = 8;
   localparam int FILL_W = 9;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_FIND   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]               command;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
   } oaids_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              found;
      logic [FPOS_W-1:0] found_position;
      logic [FILL_W-1:0] fill_count;
   } oaids_rsp_type;

   typedef struct packed {
      logic                     ins;
      logic                     del;
      logic                     find;
      logic signed [DATA_W-1:0] value;
   } oaids_ctrl_type;

endpackage

[design/oaids_cell.sv]
// one storage cell of the ordered array: entry, valid bit and match flag
// depends on oaids_pkg
module oaids_cell #(
   parameter int IDX_W = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [IDX_W-1:0]                   index,
   input  logic [IDX_W-1:0]                   pos,
   input  oaids_pkg::oaids_ctrl_type          ctrl,
   input  logic signed [oaids_pkg::DATA_W-1:0] left_entry,
   input  logic                               left_valid,
   input  logic signed [oaids_pkg::DATA_W-1:0] right_entry,
   input  logic                               right_valid,
   output logic signed [oaids_pkg::DATA_W-1:0] entry,
   output logic                               valid,
   output logic                               hit
);
   import oaids_pkg::*;

   logic signed [DATA_W-1:0] entry_ff, entry_in;
   logic                     valid_ff, valid_in;
   logic                     hit_ff, hit_in;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      hit_in   = hit_ff;
      if (ctrl.ins) begin
         if (index > pos) begin
            entry_in = left_entry;
            valid_in = left_valid;
         end else if (index == pos) begin
            entry_in = ctrl.value;
            valid_in = 1'b1;
         end
      end else if (ctrl.del) begin
         if (index >= pos) begin
            entry_in = right_entry;
            valid_in = right_valid;
         end
      end else if (ctrl.find) begin
         hit_in = valid_ff && (entry_ff == ctrl.value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;
   assign hit   = hit_ff;

endmodule

[design/oaids_tree.sv]
// registered priority tree: lowest set match flag and its index
// one register level per tree level; uses no package
module oaids_tree #(
   parameter int LEVELS = 8
) (
   input  logic                    clock,
   input  logic [(2**LEVELS)-1:0]  leaf_hits,
   output logic                    root_found,
   output logic [LEVELS-1:0]       root_position
);
   localparam int N = 2**LEVELS;

   logic              node_found_ff [N-1];
   logic [LEVELS-1:0] node_pos_ff   [N-1];

   for (genvar n = 0; n < N - 1; n++) begin : g_node
      localparam int L = 2 * n + 1;
      localparam int R = 2 * n + 2;
      logic              lf, rf;
      logic [LEVELS-1:0] lp, rp;

      if (L >= N - 1) begin : g_leaf
         assign lf = leaf_hits[L-(N-1)];
         assign rf = leaf_hits[R-(N-1)];
         assign lp = LEVELS'(L - (N - 1));
         assign rp = LEVELS'(R - (N - 1));
      end else begin : g_inner
         assign lf = node_found_ff[L];
         assign rf = node_found_ff[R];
         assign lp = node_pos_ff[L];
         assign rp = node_pos_ff[R];
      end

      always_ff @(posedge clock) begin
         node_found_ff[n] <= lf | rf;
         node_pos_ff[n]   <= lf ? lp : rp;
      end
   end

   assign root_found    = node_found_ff[0];
   assign root_position = node_pos_ff[0];

endmodule

[design/ordered_array_insert_delete_search.sv]
// channel   ports                    direction  accepted when
// request   start, busy, req_data    in         start high and busy low
// result    rsp_valid, rsp_data      out        every cycle rsp_valid is high
//
// insert, delete and unknown commands: result in the cycle after the request,
// and a new request can be taken in that same cycle.
// find: every cell compares at once, then a registered priority tree of
// clog2(CAPACITY) levels picks the lowest match; busy stays high while the
// match flags pass through the tree and the result follows as busy falls.
// after reset the array is empty; results cannot be held off.
//
// top level of the ordered array block; depends on oaids_pkg, oaids_cell,
// oaids_tree and ordered_array_insert_delete_search_defines.svh
`include "ordered_array_insert_delete_search_defines.svh"

module ordered_array_insert_delete_search #(
   parameter int CAPACITY = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  oaids_pkg::oaids_req_type req_data,
   output logic                     rsp_valid,
   output oaids_pkg::oaids_rsp_type rsp_data
);
   import oaids_pkg::*;

   localparam int LEVELS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int N       = 2**LEVELS;
   localparam int IDX_W   = LEVELS;
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int DRAIN_W = $clog2(LEVELS + 1);

   logic [CNT_W-1:0]   count_ff, count_in;
   logic               busy_ff, busy_in;
   logic [DRAIN_W-1:0] drain_ff, drain_in;
   logic               rsp_valid_ff, rsp_valid_in;
   oaids_rsp_type      rsp_data_ff, rsp_data_in;

   oaids_ctrl_type     ctrl;
   logic               accept;
   logic [CMP_W-1:0]   pos_ext, cnt_ext;
   logic               is_full, ins_ok, del_ok;
   logic [IDX_W-1:0]   cell_pos;
   logic [31:0]        cnt_wide, pos_wide;

   logic signed [DATA_W-1:0] entry_w [CAPACITY];
   logic                     valid_w [CAPACITY];
   logic [N-1:0]             leaf_hits;
   logic                     root_found;
   logic [IDX_W-1:0]         root_position;

   assign accept  = start && !busy_ff;
   assign pos_ext = CMP_W'(req_data.position);
   assign cnt_ext = CMP_W'(count_ff);
   assign is_full = (count_ff == CNT_W'(CAPACITY));
   assign ins_ok  = !is_full && (pos_ext <= cnt_ext);
   assign del_ok  = (pos_ext < cnt_ext);
   assign cell_pos = pos_ext[IDX_W-1:0];

   assign ctrl.ins   = accept && (req_data.command == CMD_INSERT) && ins_ok;
   assign ctrl.del   = accept && (req_data.command == CMD_DELETE) && del_ok;
   assign ctrl.find  = accept && (req_data.command == CMD_FIND);
   assign ctrl.value = req_data.value;

   // row of cells, each shifting with its neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_e, right_e;
      logic                     left_v, right_v;

      if (i == 0) begin : g_first
         assign left_e = '0;
         assign left_v = 1'b0;
      end else begin : g_mid_l
         assign left_e = entry_w[i-1];
         assign left_v = valid_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_e = '0;
         assign right_v = 1'b0;
      end else begin : g_mid_r
         assign right_e = entry_w[i+1];
         assign right_v = valid_w[i+1];
      end

      oaids_cell #(
         .IDX_W(IDX_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .index       (IDX_W'(i)),
         .pos         (cell_pos),
         .ctrl        (ctrl),
         .left_entry  (left_e),
         .left_valid  (left_v),
         .right_entry (right_e),
         .right_valid (right_v),
         .entry       (entry_w[i]),
         .valid       (valid_w[i]),
         .hit         (leaf_hits[i])
      );
   end

   if (N > CAPACITY) begin : g_pad
      assign leaf_hits[N-1:CAPACITY] = '0;
   end

   oaids_tree #(
      .LEVELS(LEVELS)
   ) u_tree (
      .clock         (clock),
      .leaf_hits     (leaf_hits),
      .root_found    (root_found),
      .root_position (root_position)
   );

   always_comb begin
      count_in     = count_ff;
      busy_in      = busy_ff;
      drain_in     = drain_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      cnt_wide     = 32'(count_ff);
      pos_wide     = 32'(root_position);

      if (busy_ff) begin
         if (drain_ff == '0) begin
            busy_in                    = 1'b0;
            rsp_valid_in               = 1'b1;
            rsp_data_in.status         = ST_OK;
            rsp_data_in.found          = root_found;
            rsp_data_in.found_position = root_found ? pos_wide[FPOS_W-1:0] : '0;
            rsp_data_in.fill_count     = cnt_wide[FILL_W-1:0];
         end else begin
            drain_in = drain_ff - DRAIN_W'(1);
         end
      end else if (accept) begin
         rsp_data_in.status         = ST_OK;
         rsp_data_in.found          = 1'b0;
         rsp_data_in.found_position = '0;
         if (ctrl.find) begin
            busy_in  = 1'b1;
            drain_in = DRAIN_W'(LEVELS);
         end else begin
            rsp_valid_in = 1'b1;
            case (req_data.command)
               CMD_INSERT: begin
                  if (is_full) begin
                     rsp_data_in.status = ST_FULL;
                  end else if (!ins_ok) begin
                     rsp_data_in.status = ST_RANGE;
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               CMD_DELETE: begin
                  if (!del_ok) begin
                     rsp_data_in.status = ST_RANGE;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               default: begin
               end
            endcase
            cnt_wide               = 32'(count_in);
            rsp_data_in.fill_count = cnt_wide[FILL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `OAIDS_ASSERT(a_no_result_while_busy, !(busy_ff && rsp_valid_ff), "result while busy")
   `OAIDS_ASSERT(a_count_bound, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `OAIDS_ASSERT_NEXT(a_direct_result, accept && !ctrl.find, rsp_valid_ff && !busy_ff, "missing result")
   `OAIDS_ASSERT_NEXT(a_find_busy, ctrl.find, busy_ff && !rsp_valid_ff, "find did not start")
   `OAIDS_ASSERT(a_count_only_on_request, (count_ff == $past(count_ff)) || $past(accept), "count moved without request")

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// testbench for ordered_array_insert_delete_search: directed, fill-to-capacity and random
// request streams, checked against an array image kept in the testbench; depends on oaids_pkg
module tb;
   import oaids_pkg::*;

   localparam int DEPTH       = 256;
   localparam int TREE_CYCLES = $clog2(DEPTH) + 1;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic signed [DATA_W-1:0] MAX_VALUE = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] MIN_VALUE = 32'sh8000_0000;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          start     = 1'b0;
   oaids_req_type req_data  = '0;
   logic          busy;
   logic          rsp_valid;
   oaids_rsp_type rsp_data;

   logic signed [DATA_W-1:0] array_image [DEPTH];
   int                       image_fill = 0;
   oaids_rsp_type            pending_results [$];
   int                       mismatch_count = 0;
   bit                       no_gaps = 1'b0;

   ordered_array_insert_delete_search #(.CAPACITY(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic oaids_rsp_type apply_command(oaids_req_type item);
      oaids_rsp_type outcome;
      int            pos;
      outcome = '0;
      pos = int'(item.position);
      case (item.command)
         CMD_INSERT: begin
            if (image_fill >= DEPTH) begin
               outcome.status = ST_FULL;
            end else if (pos > image_fill) begin
               outcome.status = ST_RANGE;
            end else begin
               for (int i = image_fill; i > pos; i--) array_image[i] = array_image[i - 1];
               array_image[pos] = item.value;
               image_fill++;
            end
         end
         CMD_DELETE: begin
            if (pos >= image_fill) begin
               outcome.status = ST_RANGE;
            end else begin
               for (int i = pos; i + 1 < image_fill; i++) array_image[i] = array_image[i + 1];
               image_fill--;
            end
         end
         CMD_FIND: begin
            for (int i = 0; i < image_fill; i++) begin
               if (array_image[i] == item.value) begin
                  outcome.found = 1'b1;
                  outcome.found_position = FPOS_W'(i);
                  break;
               end
            end
         end
         default: begin
         end
      endcase
      outcome.fill_count = FILL_W'(image_fill);
      return outcome;
   endfunction

   function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch %s: expected %0d, got %0d", what, want, got);
   endfunction

   always @(posedge clock) begin
      oaids_rsp_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (pending_results.size() == 0) begin
            note_mismatch("results pending", 0, 1);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.status !== want.status)
               note_mismatch("status", want.status, rsp_data.status);
            if (rsp_data.found !== want.found)
               note_mismatch("found", want.found, rsp_data.found);
            if (rsp_data.found_position !== want.found_position)
               note_mismatch("found_position", want.found_position, rsp_data.found_position);
            if (rsp_data.fill_count !== want.fill_count)
               note_mismatch("fill_count", want.fill_count, rsp_data.fill_count);
         end
      end
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return MAX_VALUE;
      if (r == 1) return MIN_VALUE;
      if (r < 6) return int'($urandom_range(0, 6)) - 3;
      return $urandom;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_present();
      if (image_fill == 0) return pick_value();
      return array_image[$urandom_range(0, image_fill - 1)];
   endfunction

   task automatic idle_for(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic send_request(logic [1:0] command, logic signed [DATA_W-1:0] value,
                               int position);
      oaids_req_type item;
      item.command  = command;
      item.value    = value;
      item.position = POS_W'(position);
      req_data <= item;
      start    <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      pending_results.push_back(apply_command(item));
      idle_for(gap_length());
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_request(CMD_DELETE, 0, 0);
      send_request(CMD_FIND, 0, 0);
      send_request(CMD_INSERT, 5, 1);
      send_request(CMD_INSERT, MAX_VALUE, 0);
      send_request(CMD_INSERT, MIN_VALUE, 1);
      send_request(CMD_INSERT, 0, 0);
      send_request(CMD_INSERT, -1, 3);
      send_request(CMD_INSERT, MAX_VALUE, 2);
      send_request(CMD_INSERT, 9, DEPTH);
      send_request(CMD_INSERT, 9, (1 << POS_W) - 1);
      send_request(CMD_FIND, MAX_VALUE, 0);
      send_request(CMD_FIND, MIN_VALUE, (1 << POS_W) - 1);
      send_request(CMD_FIND, -1, 0);
      send_request(CMD_FIND, 0, 0);
      send_request(CMD_FIND, 12345, 0);
      send_request(CMD_DELETE, 0, 5);
      send_request(CMD_DELETE, 0, (1 << POS_W) - 1);
      send_request(CMD_DELETE, 0, 4);
      send_request(CMD_FIND, -1, 0);
      send_request(CMD_DELETE, 0, 0);
      send_request(CMD_FIND, MAX_VALUE, 0);
      send_request(CMD_UNUSED, -1, (1 << POS_W) - 1);
      send_request(CMD_UNUSED, 0, 0);
   endtask

   task automatic test_fill_to_capacity();
      while (image_fill < DEPTH) send_request(CMD_INSERT, pick_value(), $urandom_range(0, image_fill));
      send_request(CMD_INSERT, 1, 0);
      send_request(CMD_INSERT, -5, 300);
      send_request(CMD_INSERT, 7, (1 << POS_W) - 1);
      send_request(CMD_FIND, array_image[DEPTH - 1], 0);
      send_request(CMD_FIND, array_image[0], 0);
      send_request(CMD_DELETE, 0, DEPTH);
      send_request(CMD_DELETE, 0, DEPTH - 1);
      send_request(CMD_INSERT, $urandom, DEPTH - 1);
      send_request(CMD_FIND, array_image[DEPTH - 1], 0);
      send_request(CMD_DELETE, 0, 0);
      wait_quiet();
   endtask

   task automatic test_random_mix();
      int                       insert_share;
      int                       r;
      int                       pos;
      logic [1:0]               command;
      logic signed [DATA_W-1:0] value;
      for (int n = 0; n < 330; n++) begin
         if (n % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
         if (n == 165) wait_quiet();
         insert_share = image_fill < 64 ? 55 : (image_fill > 200 ? 22 : 38);
         r = $urandom_range(0, 99);
         if (r < insert_share) command = CMD_INSERT;
         else if (r < insert_share + 30) command = CMD_DELETE;
         else if (r < 96) command = CMD_FIND;
         else command = CMD_UNUSED;
         if ($urandom_range(0, 99) < 12) pos = $urandom_range(0, (1 << POS_W) - 1);
         else if (command == CMD_DELETE) pos = image_fill > 0 ? $urandom_range(0, image_fill - 1) : 0;
         else pos = $urandom_range(0, image_fill);
         if (command == CMD_FIND && $urandom_range(0, 1) == 1) value = pick_present();
         else value = pick_value();
         send_request(command, value, pos);
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_to_capacity();
      test_random_mix();
      start <= 1'b0;
      for (int n = 0; n < 2000 && pending_results.size() != 0; n++) @(posedge clock);
      repeat (TREE_CYCLES + 4) @(posedge clock);
      if (pending_results.size() != 0) note_mismatch("results pending", 0, pending_results.size());
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
